>>> design/llpb_pkg.sv
package llpb_pkg;

    localparam int MASK_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 3;
    localparam int PORT_W  = 3;
    localparam int LOAD_W  = 8;

    localparam logic ACT_BIND    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic capture;
        logic execute;
    } llpb_cmd_t;

endpackage

>>> design/llpb_ctrl.sv
module llpb_ctrl
    import llpb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output llpb_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/llpb_dp.sv
module llpb_dp
    import llpb_pkg::*;
#(
    parameter int NUM_PORTS   = 8,
    parameter int NUM_CLASSES = 8,
    parameter int COUNT_WIDTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  llpb_cmd_t          cmd,
    input  logic               cfg_wr_en,
    input  logic [MASK_W-1:0]  cfg_wr_data,
    input  logic               action,
    input  logic [CLASS_W-1:0] unit_class,
    input  logic               skip_binding,
    input  logic [PORT_W-1:0]  release_port,
    output logic [PORT_W-1:0]  chosen_port,
    output logic               bound,
    output logic               fault,
    output logic [LOAD_W-1:0]  load_after
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [MASK_W-1:0]      mask_reg;
    logic [COUNT_WIDTH-1:0] load_reg  [NUM_PORTS];
    logic [COUNT_WIDTH-1:0] load_next [NUM_PORTS];

    logic                   action_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic                   skip_reg;
    logic [PORT_W-1:0]      rport_reg;

    logic [PORT_W-1:0]      chosen_reg, chosen_next;
    logic                   bound_reg, bound_next;
    logic                   fault_reg, fault_next;
    logic [LOAD_W-1:0]      load_after_reg, load_after_next;

    logic [BYTE_W-1:0]      class_mask;
    logic                   found;
    logic [COUNT_WIDTH-1:0] best_cnt;
    logic [PORT_W-1:0]      best_idx;
    logic                   rel_hit;
    logic [COUNT_WIDTH-1:0] rel_cnt;
    logic                   do_inc;
    logic                   do_dec;

    always_comb
    begin
        if (int'(class_reg) < NUM_CLASSES)
        begin
            class_mask = mask_reg[{class_reg, 3'b000} +: BYTE_W];
        end
        else
        begin
            class_mask = '0;
        end
        found    = 1'b0;
        best_cnt = '0;
        best_idx = '0;
        rel_hit  = 1'b0;
        rel_cnt  = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (class_mask[p] && (!found || load_reg[p] < best_cnt))
            begin
                found    = 1'b1;
                best_cnt = load_reg[p];
                best_idx = PORT_W'(p);
            end
            if (rport_reg == PORT_W'(p))
            begin
                rel_hit = 1'b1;
                rel_cnt = load_reg[p];
            end
        end
    end

    always_comb
    begin
        chosen_next     = '0;
        bound_next      = 1'b0;
        fault_next      = 1'b0;
        load_after_next = '0;
        do_inc          = 1'b0;
        do_dec          = 1'b0;
        if (action_reg == ACT_RELEASE)
        begin
            if (!rel_hit || rel_cnt == '0)
            begin
                fault_next = 1'b1;
            end
            else
            begin
                do_dec          = 1'b1;
                load_after_next = LOAD_W'(rel_cnt - 1'b1);
            end
        end
        else if (!skip_reg)
        begin
            if (!found)
            begin
                fault_next = 1'b1;
            end
            else if (best_cnt == CNT_MAX)
            begin
                fault_next      = 1'b1;
                load_after_next = LOAD_W'(best_cnt);
            end
            else
            begin
                do_inc          = 1'b1;
                chosen_next     = best_idx;
                bound_next      = 1'b1;
                load_after_next = LOAD_W'(best_cnt + 1'b1);
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            load_next[p] = load_reg[p];
            if (cmd.execute && do_inc && best_idx == PORT_W'(p))
            begin
                load_next[p] = load_reg[p] + 1'b1;
            end
            else if (cmd.execute && do_dec && rport_reg == PORT_W'(p))
            begin
                load_next[p] = load_reg[p] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                load_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                load_reg[p] <= load_next[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            class_reg  <= unit_class;
            skip_reg   <= skip_binding;
            rport_reg  <= release_port;
        end
        if (cmd.execute)
        begin
            chosen_reg     <= chosen_next;
            bound_reg      <= bound_next;
            fault_reg      <= fault_next;
            load_after_reg <= load_after_next;
        end
    end

    assign chosen_port = chosen_reg;
    assign bound       = bound_reg;
    assign fault       = fault_reg;
    assign load_after  = load_after_reg;

endmodule

>>> design/least_loaded_port_binder_core.sv
// An input transfer is captured into the datapath's request registers and the
// controller moves to its execute step, which registers the result and sets
// out_valid. No new input is taken until the execute step is done; an execute
// step waits while a stalled result still occupies the output register.
// Reset (rst_n low, asynchronous): all load counts and the class masks clear,
// no result is valid and the block is ready for an input transfer.
module least_loaded_port_binder_core
    import llpb_pkg::*;
#(
    parameter int NUM_PORTS   = 8,
    parameter int NUM_CLASSES = 8,
    parameter int COUNT_WIDTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [MASK_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [CLASS_W-1:0] unit_class,
    input  logic               skip_binding,
    input  logic [PORT_W-1:0]  release_port,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PORT_W-1:0]  chosen_port,
    output logic               bound,
    output logic               fault,
    output logic [LOAD_W-1:0]  load_after
);

    llpb_cmd_t cmd;

    llpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    llpb_dp #(
        .NUM_PORTS   (NUM_PORTS),
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .action       (action),
        .unit_class   (unit_class),
        .skip_binding (skip_binding),
        .release_port (release_port),
        .chosen_port  (chosen_port),
        .bound        (bound),
        .fault        (fault),
        .load_after   (load_after)
    );

endmodule

>>> design/llpb_chk.sv
module llpb_chk
    import llpb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [PORT_W-1:0] chosen_port,
    input logic              bound,
    input logic              fault
);

    a_bound_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bound |-> !fault)
        else $error("bound result also flags a fault");

    a_port_zero_unbound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bound |-> chosen_port == '0)
        else $error("nonzero port on an unbound result");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !(out_valid && out_stall) |=> ##1 out_valid)
        else $error("no result two cycles after an input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_port))
        else $error("stalled result dropped or changed");

endmodule

bind least_loaded_port_binder_core llpb_chk u_llpb_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chosen_port (chosen_port),
    .bound       (bound),
    .fault       (fault)
);

>>> dv/tb_least_loaded_port_binder_core.sv
module tb_least_loaded_port_binder_core
    import llpb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPORTS         = 8;
    localparam int NCLASSES       = 8;
    localparam int CNT_W          = 8;
    localparam int CNT_MAX        = (1 << CNT_W) - 1;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int NUM_PHASES     = 6;

    typedef struct packed {
        logic               act;
        logic [CLASS_W-1:0] cls;
        logic               skip;
        logic [PORT_W-1:0]  rport;
    } bind_req_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              bound;
        logic              fault;
        logic [LOAD_W-1:0] load;
    } bind_resp_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        bind_req_t         req;
        logic              typed;
        bind_resp_t        resp;
        logic [MASK_W-1:0] cfg;
    } dir_row_t;

    localparam bind_resp_t RESP_NONE   = '{3'd0, 1'b0, 1'b0, 8'd0};
    localparam bind_resp_t RESP_FAULT  = '{3'd0, 1'b0, 1'b1, 8'd0};
    localparam bind_resp_t RESP_ONE_P0 = '{3'd0, 1'b1, 1'b0, 8'd1};
    localparam logic [MASK_W-1:0] NO_CFG   = '0;
    localparam logic [MASK_W-1:0] MIX_MASK = 64'h8180_0100_00FF_0280;

    localparam int NUM_ROWS = 23;
    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM, '{ACT_BIND,    3'd0, 1'b0, 3'd0}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd7, 1'b0, 3'd7}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd5, 1'b1, 3'd2}, 1'b1, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd0, 1'b0, 3'd0}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd7, 1'b1, 3'd7}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_CFG,  '0,                               1'b0, RESP_NONE,   '1},
        '{ROW_ITEM, '{ACT_BIND,    3'd0, 1'b0, 3'd5}, 1'b1, RESP_ONE_P0, NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd7, 1'b0, 3'd0}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd3, 1'b0, 3'd7}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd4, 1'b1, 3'd0}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd2, 1'b1, 3'd3}, 1'b1, RESP_NONE,   NO_CFG},
        '{ROW_CFG,  '0,                               1'b0, RESP_NONE,   MIX_MASK},
        '{ROW_ITEM, '{ACT_BIND,    3'd0, 1'b0, 3'd0}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd3, 1'b0, 3'd0}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd4, 1'b0, 3'd1}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd7, 1'b0, 3'd2}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd2, 1'b0, 3'd4}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd0, 1'b0, 3'd7}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd6, 1'b1, 3'd7}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd1, 1'b0, 3'd6}, 1'b1, RESP_FAULT,  NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd5, 1'b1, 3'd5}, 1'b1, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_RELEASE, 3'd2, 1'b0, 3'd1}, 1'b0, RESP_NONE,   NO_CFG},
        '{ROW_ITEM, '{ACT_BIND,    3'd1, 1'b0, 3'd3}, 1'b0, RESP_NONE,   NO_CFG}
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [MASK_W-1:0]  cfg_wr_data  = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               action       = ACT_BIND;
    logic [CLASS_W-1:0] unit_class   = '0;
    logic               skip_binding = 1'b0;
    logic [PORT_W-1:0]  release_port = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [PORT_W-1:0]  chosen_port;
    logic               bound;
    logic               fault;
    logic [LOAD_W-1:0]  load_after;

    logic [CNT_W-1:0]   port_load_q [NPORTS];
    logic [MASK_W-1:0]  class_masks_q = '0;
    bind_resp_t         results_due [$];
    int                 mismatch_count = 0;
    bit                 tx_idle_en     = 1'b1;
    bit                 rx_idle_en     = 1'b1;
    bit                 rx_hold_req    = 1'b0;

    least_loaded_port_binder_core #(
        .NUM_PORTS   (NPORTS),
        .NUM_CLASSES (NCLASSES),
        .COUNT_WIDTH (CNT_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .unit_class   (unit_class),
        .skip_binding (skip_binding),
        .release_port (release_port),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chosen_port  (chosen_port),
        .bound        (bound),
        .fault        (fault),
        .load_after   (load_after)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("tb_least_loaded_port_binder_core NOT OK");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bind_resp_t bind_outcome(input bind_req_t req);
        bind_resp_t        res;
        logic [BYTE_W-1:0] elig;
        int                best;
        res  = RESP_NONE;
        best = -1;
        if (req.act == ACT_RELEASE)
        begin
            if (int'(req.rport) >= NPORTS || port_load_q[req.rport] == 0)
            begin
                res.fault = 1'b1;
            end
            else
            begin
                port_load_q[req.rport] = port_load_q[req.rport] - 1'b1;
                res.load = LOAD_W'(port_load_q[req.rport]);
            end
        end
        else if (!req.skip)
        begin
            elig = '0;
            if (int'(req.cls) < NCLASSES)
                elig = class_masks_q[BYTE_W*req.cls +: BYTE_W];
            for (int p = 0; p < NPORTS; p++)
            begin
                if (elig[p] && (best < 0 || port_load_q[p] < port_load_q[best]))
                    best = p;
            end
            if (best < 0)
            begin
                res.fault = 1'b1;
            end
            else if (int'(port_load_q[best]) >= CNT_MAX)
            begin
                res.fault = 1'b1;
                res.load  = LOAD_W'(port_load_q[best]);
            end
            else
            begin
                port_load_q[best] = port_load_q[best] + 1'b1;
                res.port  = best[PORT_W-1:0];
                res.bound = 1'b1;
                res.load  = LOAD_W'(port_load_q[best]);
            end
        end
        return res;
    endfunction

    // drop valid, wait out all results, then write the mask register
    task automatic drain_and_write(input logic [MASK_W-1:0] value);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        class_masks_q  = value;
    endtask

    task automatic offer(input bind_req_t req, input logic typed,
                         input bind_resp_t typed_resp, input bit pause_first);
        int         gap;
        bind_resp_t pred;
        gap = tx_idle_en ? idle_len() : 0;
        if (pause_first && gap == 0) gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (pause_first)
                while (results_due.size() != 0) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= req.act;
        unit_class   <= req.cls;
        skip_binding <= req.skip;
        release_port <= req.rport;
        do @(posedge clk); while (in_stall);
        pred = bind_outcome(req);
        results_due.push_back(typed ? typed_resp : pred);
    endtask

    initial
    begin : result_sink
        int         stall_run;
        bind_resp_t want;
        bind_resp_t got;
        stall_run = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = '{chosen_port, bound, fault, load_after};
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "unexpected result: port %0d bound %0b fault %0b load %0d",
                            got.port, got.bound, got.fault, got.load);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.port !== want.port || got.bound !== want.bound ||
                        got.fault !== want.fault || got.load !== want.load)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display(
                                "exp/act port %0d/%0d bound %0b/%0b fault %0b/%0b load %0d/%0d",
                                want.port, got.port, want.bound, got.bound,
                                want.fault, got.fault, want.load, got.load);
                    end
                end
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (rx_idle_en && $urandom_range(0, 3) == 0)
                    stall_run = idle_len();
            end
        end
    end

    initial
    begin : stimulus
        int                n_items;
        int                bind_pct;
        logic [MASK_W-1:0] mask_val;
        bind_req_t         req;
        for (int p = 0; p < NPORTS; p++) port_load_q[p] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                drain_and_write(DIRECTED[i].cfg);
            else
                offer(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].resp, 1'b0);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            mask_val   = {$urandom, $urandom};
            n_items    = 150;
            bind_pct   = 60;
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
            case (ph)
                1:
                begin
                    mask_val   = '1;
                    bind_pct   = 55;
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                // every class on port 0: drive its count up to saturation
                2:
                begin
                    mask_val = 64'h0101_0101_0101_0101;
                    n_items  = 360;
                    bind_pct = 95;
                end
                3:
                begin
                    mask_val = '0;
                    n_items  = 60;
                    bind_pct = 50;
                end
                default: ;
            endcase
            if (ph == 5)
            begin
                n_items  = 200;
                bind_pct = 50;
            end
            drain_and_write(mask_val);
            if (ph == 4)
            begin
                tx_idle_en  = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (int k = 0; k < n_items; k++)
            begin
                req.act   = ($urandom_range(0, 99) < bind_pct) ? ACT_BIND : ACT_RELEASE;
                req.cls   = CLASS_W'($urandom_range(0, NCLASSES - 1));
                req.skip  = ($urandom_range(0, 15) == 0);
                req.rport = PORT_W'($urandom_range(0, NPORTS - 1));
                offer(req, 1'b0, RESP_NONE, (ph == 5 && k == 100));
            end
        end

        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("tb_least_loaded_port_binder_core OK");
        else
            $display("tb_least_loaded_port_binder_core NOT OK");
        $finish;
    end

endmodule

>>> least_loaded_port_binder_core.f
design/llpb_pkg.sv
design/llpb_ctrl.sv
design/llpb_dp.sv
design/least_loaded_port_binder_core.sv
design/llpb_chk.sv
dv/tb_least_loaded_port_binder_core.sv
